FILE: hw/rtl/rwf_pkg.sv
// Shared types, constants and control structs for the replay window filter.
package rwf_pkg;

  localparam int unsigned SeqW        = 64;
  localparam int unsigned VerdictW    = 2;
  localparam int unsigned SlotsDef    = 256;
  localparam int unsigned ModStepBits = 4;
  localparam int unsigned ModSteps    = SeqW / ModStepBits;
  localparam int unsigned ModCntW     = $clog2(ModSteps);
  localparam int unsigned OutDataW    = ((VerdictW + 7) / 8) * 8;
  localparam int unsigned CfgAddrW    = 4;
  localparam int unsigned CfgDataW    = 64;

  localparam logic [SeqW-1:0] SlotEmpty = '1;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_TOO_OLD   = 2'd1,
    VERDICT_DUPLICATE = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic mod_step;
    logic rd_en;
    logic commit;
  } rwf_cmd_t;

  typedef struct packed {
    logic clr_last;
  } rwf_sts_t;

endpackage

FILE: hw/rtl/replay_window_filter.sv
// Top level of the replay window filter: stream channels, register port and submodules.
// The controller handles one item at a time through slot selection (a 4-bit-per-cycle slot
// remainder unit when SLOTS is not a power of two), memory read and commit; the commit
// waits while a previous result is still held on a stalled output.
// Reset: synchronous active-low; afterwards every slot of the memory is cleared to all ones,
// during which in_tready stays low and register writes are still taken.
module replay_window_filter #(
  parameter int unsigned SLOTS = rwf_pkg::SlotsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rwf_pkg::SeqW-1:0]       in_tdata,   // [63:0] sequence_number
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rwf_pkg::OutDataW-1:0]   out_tdata,  // [1:0] verdict, [7:2] zero
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rwf_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [rwf_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [rwf_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  rwf_pkg::rwf_cmd_t        cmd;
  rwf_pkg::rwf_sts_t        sts;
  logic                     seed_we;
  logic                     seed_sel;
  logic [rwf_pkg::SeqW-1:0] seed;
  rwf_pkg::verdict_t        verdict;

  assign cfg_pready = 1'b1;
  assign seed_sel   = !cfg_paddr[rwf_pkg::CfgAddrW-1];
  assign seed_we    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && seed_sel;
  assign cfg_prdata = seed_sel ? seed : '0;

  rwf_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwf_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .seq_in  (in_tdata),
    .seed_we (seed_we),
    .seed_in (cfg_pwdata),
    .seed    (seed),
    .verdict (verdict)
  );

  assign out_tdata = rwf_pkg::OutDataW'(verdict);

endmodule

FILE: hw/rtl/rwf_ctrl.sv
// Controller state machine that sequences clearing, slot selection, lookup and commit.
module rwf_ctrl #(
  parameter int unsigned SLOTS = rwf_pkg::SlotsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rwf_pkg::rwf_sts_t  sts,
  output rwf_pkg::rwf_cmd_t  cmd
);

  localparam bit IsPow2 = (SLOTS & (SLOTS - 1)) == 0;

  rwf_pkg::state_t                 state_r, state_nxt;
  logic [rwf_pkg::ModCntW-1:0]     mod_cnt_r, mod_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwf_pkg::ST_CLEAR;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mod_cnt_nxt = mod_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      rwf_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = rwf_pkg::ST_IDLE;
        end
      end
      rwf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          mod_cnt_nxt = '0;
          state_nxt   = IsPow2 ? rwf_pkg::ST_READ : rwf_pkg::ST_MOD;
        end
      end
      rwf_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        mod_cnt_nxt  = mod_cnt_r + 1'b1;
        if (mod_cnt_r == rwf_pkg::ModCntW'(rwf_pkg::ModSteps - 1)) begin
          state_nxt = rwf_pkg::ST_READ;
        end
      end
      rwf_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = rwf_pkg::ST_DECIDE;
      end
      rwf_pkg::ST_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = rwf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rwf_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/rwf_datapath.sv
// Datapath with the slot memory, highest sequence, slot index reduction and verdict logic.
module rwf_datapath #(
  parameter int unsigned SLOTS = rwf_pkg::SlotsDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rwf_pkg::rwf_cmd_t           cmd,
  output rwf_pkg::rwf_sts_t           sts,
  input  logic [rwf_pkg::SeqW-1:0]    seq_in,
  input  logic                        seed_we,
  input  logic [rwf_pkg::SeqW-1:0]    seed_in,
  output logic [rwf_pkg::SeqW-1:0]    seed,
  output rwf_pkg::verdict_t           verdict
);

  localparam int unsigned IdxW   = $clog2(SLOTS);
  localparam int unsigned RemW   = IdxW + 1;
  localparam bit          IsPow2 = (SLOTS & (SLOTS - 1)) == 0;

  logic [rwf_pkg::SeqW-1:0] mem [SLOTS];

  logic [rwf_pkg::SeqW-1:0] seed_r;
  logic [rwf_pkg::SeqW-1:0] highest_r;
  logic [rwf_pkg::SeqW-1:0] seq_r;
  logic [rwf_pkg::SeqW-1:0] sum_r;
  logic [IdxW-1:0]          rem_r, rem_nxt;
  logic [IdxW-1:0]          clr_idx_r;
  logic [rwf_pkg::SeqW-1:0] held_r;
  logic                     too_old_r;
  logic                     raise_r;
  rwf_pkg::verdict_t        verdict_r;

  logic [IdxW-1:0]          slot_idx;
  logic [rwf_pkg::SeqW-1:0] reach;
  logic                     fresh;
  logic                     mem_we;
  logic [IdxW-1:0]          mem_wa;
  logic [rwf_pkg::SeqW-1:0] mem_wd;

  always_comb begin
    logic [IdxW-1:0] r;
    logic [RemW-1:0] t;
    r = rem_r;
    t = '0;
    for (int k = 0; k < int'(rwf_pkg::ModStepBits); k++) begin
      t = {r, sum_r[rwf_pkg::SeqW-1-k]};
      if (t >= RemW'(SLOTS)) begin
        t = t - RemW'(SLOTS);
      end
      r = t[IdxW-1:0];
    end
    rem_nxt = r;
  end

  assign slot_idx = IsPow2 ? sum_r[IdxW-1:0] : rem_r;
  assign reach    = seq_r + rwf_pkg::SeqW'(SLOTS);
  assign fresh    = (held_r == rwf_pkg::SlotEmpty) || (held_r < seq_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_idx;
    mem_wd = seq_r;
    if (cmd.clr_we) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = rwf_pkg::SlotEmpty;
    end else if (cmd.commit && !too_old_r && fresh) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      held_r <= mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      highest_r <= '0;
      clr_idx_r <= '0;
    end else begin
      if (seed_we) begin
        seed_r <= seed_in;
      end
      if (cmd.clr_we) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.commit && !too_old_r && raise_r) begin
        highest_r <= seq_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= seq_in;
      sum_r <= seq_in + seed_r;
      rem_r <= '0;
    end else if (cmd.mod_step) begin
      sum_r <= sum_r << rwf_pkg::ModStepBits;
      rem_r <= rem_nxt;
    end
    if (cmd.rd_en) begin
      too_old_r <= reach < highest_r;
      raise_r   <= highest_r < seq_r;
    end
    if (cmd.commit) begin
      if (too_old_r) begin
        verdict_r <= rwf_pkg::VERDICT_TOO_OLD;
      end else if (fresh) begin
        verdict_r <= rwf_pkg::VERDICT_ACCEPT;
      end else begin
        verdict_r <= rwf_pkg::VERDICT_DUPLICATE;
      end
    end
  end

  assign sts.clr_last = clr_idx_r == IdxW'(SLOTS - 1);
  assign seed         = seed_r;
  assign verdict      = verdict_r;

endmodule

FILE: hw/rtl/rwf_checker.sv
// Port-level checker for the replay window filter and its bind statement.
module rwf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rwf_pkg::OutDataW-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result item changed or dropped.");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("Result item carries an undefined verdict code.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[rwf_pkg::OutDataW-1:rwf_pkg::VerdictW] == '0)
    else $error("Result item padding bits are not zero.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input item accepted while the previous one is in flight.");

endmodule

bind replay_window_filter rwf_checker u_rwf_checker (.*);

FILE: bench/tb_replay_window_filter.sv
`timescale 1ns / 1ps
// Testbench for the replay window filter: directed and random streams against a predictor.
module tb_replay_window_filter;

  localparam int unsigned Slots = rwf_pkg::SlotsDef;
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned LongHold = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomPerPhase = 262;
  localparam int unsigned HistoryDepth = 24;
  localparam logic [rwf_pkg::CfgAddrW-1:0] AddrHashSeed = 4'h0;
  localparam logic [rwf_pkg::CfgAddrW-1:0] AddrUnmapped = 4'h8;
  localparam logic [rwf_pkg::SeqW-1:0] AllOnes = '1;
  localparam logic [rwf_pkg::SeqW-1:0] TopBit = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPattern
  } stall_mode_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [rwf_pkg::SeqW-1:0]     in_tdata = '0;   // [63:0] sequence_number
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [rwf_pkg::OutDataW-1:0] out_tdata;       // [1:0] verdict, [7:2] zero
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [rwf_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [rwf_pkg::CfgDataW-1:0] cfg_pwdata = '0;
  logic [rwf_pkg::CfgDataW-1:0] cfg_prdata;
  logic                         cfg_pready;

  logic [rwf_pkg::SeqW-1:0] seed_shadow;
  logic [rwf_pkg::SeqW-1:0] peak_seq;
  logic [rwf_pkg::SeqW-1:0] slot_shadow [Slots];
  rwf_pkg::verdict_t        verdicts_due [$];
  logic [rwf_pkg::SeqW-1:0] recent_seqs [$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned seeds_written = 0;
  int unsigned tally [3] = '{0, 0, 0};
  int unsigned burst_left = 0;
  int unsigned hold_cmd = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  stall_mode_t stall_mode = StallNone;
  logic [7:0]  stall_pattern = 8'h01;

  replay_window_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic rwf_pkg::verdict_t judge_sequence(input logic [rwf_pkg::SeqW-1:0] seq);
    logic [rwf_pkg::SeqW-1:0] reach;
    logic [rwf_pkg::SeqW-1:0] pick;
    int unsigned              idx;
    reach = seq + rwf_pkg::SeqW'(Slots);
    if (reach < peak_seq) return rwf_pkg::VERDICT_TOO_OLD;
    if (peak_seq < seq) peak_seq = seq;
    pick = seq + seed_shadow;
    idx = int'(pick % rwf_pkg::SeqW'(Slots));
    if (slot_shadow[idx] == rwf_pkg::SlotEmpty || slot_shadow[idx] < seq) begin
      slot_shadow[idx] = seq;
      return rwf_pkg::VERDICT_ACCEPT;
    end
    return rwf_pkg::VERDICT_DUPLICATE;
  endfunction

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin : score_verdicts
    rwf_pkg::verdict_t due;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0d arrived with no item outstanding", out_tdata));
      end else begin
        due = verdicts_due.pop_front();
        tally[due]++;
        if (out_tdata !== rwf_pkg::OutDataW'(due))
          report_mismatch($sformatf("out_tdata %h, expected verdict %s", out_tdata, due.name()));
      end
    end
    if (rst_n && in_tvalid && in_tready) verdicts_due.push_back(judge_sequence(in_tdata));
  end

  always @(posedge clk) begin : pace_out_ready
    if (hold_seen != hold_cmd) begin
      hold_seen <= hold_cmd;
      hold_left <= LongHold;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(16, 160);
      stall_pattern <= 8'($urandom) | 8'h01;
      out_tready <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      case (stall_mode)
        StallNone: out_tready <= 1'b1;
        StallRandom: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= stall_pattern[0];
      endcase
    end
  end

  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles.", IdleLimit);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_sequence(input logic [rwf_pkg::SeqW-1:0] seq);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= seq;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    recent_seqs.push_back(seq);
    if (recent_seqs.size() > HistoryDepth) void'(recent_seqs.pop_front());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic write_register(input logic [rwf_pkg::CfgAddrW-1:0] addr,
                                input logic [rwf_pkg::CfgDataW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == AddrHashSeed) begin
      seed_shadow = value;
      seeds_written++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_seed_readback();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= AddrHashSeed;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== seed_shadow)
      report_mismatch($sformatf("hash_seed reads %h, expected %h", cfg_prdata, seed_shadow));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly sequences around the running maximum, so that slots fill, age out and repeat.
  function automatic logic [rwf_pkg::SeqW-1:0] pick_sequence();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 68)
      return peak_seq + rwf_pkg::SeqW'($urandom_range(0, 340)) - rwf_pkg::SeqW'(300);
    if (roll < 80 && recent_seqs.size() != 0)
      return recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
    if (roll < 88) return peak_seq + rwf_pkg::SeqW'($urandom_range(1, 1 << 16));
    if (roll < 94) return {$urandom, $urandom};
    return AllOnes - rwf_pkg::SeqW'($urandom_range(0, Slots - 1));
  endfunction

  task automatic test_seed_register();
    write_register(AddrHashSeed, '0);
    check_seed_readback();
    write_register(AddrUnmapped, {$urandom, $urandom});
    check_seed_readback();
  endtask

  task automatic test_directed_window();
    logic [rwf_pkg::SeqW-1:0] opening [12] = '{
      64'd0, 64'd0, 64'd256, 64'd0, 64'd255, 64'd511, 64'd254, 64'd255,
      AllOnes, 64'hFFFF_FFFF_FFFF_FF00, 64'd600, 64'd600};
    logic [rwf_pkg::SeqW-1:0] shifted [4] = '{64'd601, 64'd600, 64'd856, 64'd344};
    foreach (opening[i]) send_sequence(opening[i]);
    wait_drained();
    write_register(AddrHashSeed, AllOnes);
    check_seed_readback();
    foreach (shifted[i]) send_sequence(shifted[i]);
    wait_drained();
  endtask

  task automatic test_random_phase(input logic [rwf_pkg::SeqW-1:0] seed);
    wait_drained();
    write_register(AddrHashSeed, seed);
    check_seed_readback();
    repeat (RandomPerPhase) send_sequence(pick_sequence());
  endtask

  task automatic test_backpressure();
    hold_cmd++;
    repeat (24) send_sequence(pick_sequence());
    wait_drained();
  endtask

  initial begin : run_tests
    seed_shadow = '0;
    peak_seq = '0;
    foreach (slot_shadow[i]) slot_shadow[i] = rwf_pkg::SlotEmpty;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_seed_register();
    test_directed_window();
    test_random_phase({$urandom, $urandom});
    test_backpressure();
    test_random_phase(64'd1);
    test_random_phase(AllOnes);
    test_random_phase(TopBit);
    test_random_phase('0);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    $display("Verdicts checked: %0d accepted, %0d too old, %0d duplicate.",
             tally[rwf_pkg::VERDICT_ACCEPT], tally[rwf_pkg::VERDICT_TOO_OLD],
             tally[rwf_pkg::VERDICT_DUPLICATE]);
    $display("Hash seed loaded %0d times across directed, random and stalled phases.",
             seeds_written);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rwf_pkg.sv
hw/rtl/rwf_ctrl.sv
hw/rtl/rwf_datapath.sv
hw/rtl/replay_window_filter.sv
hw/rtl/rwf_checker.sv
bench/tb_replay_window_filter.sv
